// ===== design/rxm_pkg.sv =====
`timescale 1ns / 1ps
package rxm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = 16;              // chromaticity width
	localparam int LW        = 17;              // white luminance width
	localparam int OW        = 20;              // column output width, Q3.16
	localparam int PW        = 2 * CW + 2;      // signed products of 17-bit operands
	localparam int SW        = PW + 1;          // signed determinant and cofactor sums
	localparam int MW        = SW - 1;          // their magnitudes
	localparam int CAW       = CW + 1;          // |chroma coefficient|
	localparam int LCW       = LW + CAW;        // lum * |coefficient|
	localparam int NUMW      = LCW + MW;        // full numerator
	localparam int DENW      = MW + CW;         // |D| * white_y
	localparam int DPW       = DENW + 1;        // doubled divisor
	localparam int RW        = NUMW + 2;        // rounded dividend and remainder
	localparam int QW        = OW;              // quotient bits, top bit flags overflow
	localparam int NCOL      = 9;
	localparam int FRONT     = 5;               // stages ahead of the divider
	localparam int DEPTH     = FRONT + QW + 1;  // plus the output register

	typedef struct packed {
		logic [CW-1:0] red_x;
		logic [CW-1:0] red_y;
		logic [CW-1:0] green_x;
		logic [CW-1:0] green_y;
		logic [CW-1:0] blue_x;
		logic [CW-1:0] blue_y;
		logic [LW-1:0] white_lum;
		logic [CW-1:0] white_x;
		logic [CW-1:0] white_y;
	} item_t;

	typedef struct packed {
		logic [RW-1:0] num;   // 2*lum*|c|*|N| + den
		logic          neg;   // sign of the column value
	} col_t;

	// Round-half-away quotient to saturated signed column value
	function automatic logic [OW-1:0] col_out(logic [QW-1:0] q, logic neg, logic deg);
		logic          sat;
		logic [OW-1:0] mag;
		logic [OW-1:0] res;
		sat = q[QW-1];
		mag = {1'b0, q[QW-2:0]};
		if (deg) begin
			res = '0;
		end else if (!neg) begin
			res = sat ? {1'b0, {(OW-1){1'b1}}} : mag;
		end else begin
			res = sat ? {1'b1, {(OW-1){1'b0}}} : (~mag + OW'(1));
		end
		return res;
	endfunction

endpackage

// ===== design/rxm_front.sv =====
`timescale 1ns / 1ps
module rxm_front (
	input  logic                       clk,
	input  logic                       en,
	input  rxm_pkg::item_t             item,
	output rxm_pkg::col_t  [8:0]       cols,
	output logic [rxm_pkg::DPW-1:0]    dden,
	output logic                       deg
);
	import rxm_pkg::*;

	localparam logic signed [CW+1:0] ONE_V = (CW+2)'(1) << FRAC_BITS;

	logic signed [CW:0] xs [3];
	logic signed [CW:0] ys [3];
	logic signed [CW:0] wx, wy;
	logic signed [CW:0] dy [3];
	logic signed [CW:0] dx [3];
	logic signed [CW+1:0] cz [3];
	logic [CAW-1:0] cabs_c [NCOL];
	logic           cneg_c [NCOL];

	// stage 1 registers
	logic signed [PW-1:0] dt_s1 [3];
	logic signed [PW-1:0] ax_s1 [3];
	logic signed [PW-1:0] bw_s1 [3];
	logic signed [PW-1:0] ca_s1 [3];
	logic signed [PW-1:0] cb_s1 [3];
	logic [CAW-1:0]       cabs_s1 [NCOL];
	logic                 cneg_s1 [NCOL];
	logic [LW-1:0]        lum_s1;
	logic [CW-1:0]        wy_s1;
	logic                 degy_s1;

	// stage 2 registers
	logic signed [SW-1:0] dd_s2;
	logic signed [SW-1:0] nn_s2 [3];
	logic [LCW-1:0]       lumc_s2 [NCOL];
	logic                 cneg_s2 [NCOL];
	logic [CW-1:0]        wy_s2;
	logic                 degy_s2;

	// stage 3 registers
	logic [DENW-1:0] den_s3;
	logic            dneg_s3;
	logic            deg_s3;
	logic [MW-1:0]   nmag_s3 [3];
	logic            nneg_s3 [3];
	logic [LCW-1:0]  lumc_s3 [NCOL];
	logic            cneg_s3 [NCOL];

	// stage 4 registers
	logic [NUMW-1:0] num_s4 [NCOL];
	logic            neg_s4 [NCOL];
	logic [DENW-1:0] den_s4;
	logic            deg_s4;

	// stage 5 registers
	col_t [8:0]      cols_s5;
	logic [DPW-1:0]  dden_s5;
	logic            deg_s5;

	logic [SW-1:0]   dd_abs;
	logic [SW-1:0]   nn_abs [3];

	// operand extension and coefficient magnitudes
	always_comb begin
		xs[0] = signed'({1'b0, item.red_x});
		ys[0] = signed'({1'b0, item.red_y});
		xs[1] = signed'({1'b0, item.green_x});
		ys[1] = signed'({1'b0, item.green_y});
		xs[2] = signed'({1'b0, item.blue_x});
		ys[2] = signed'({1'b0, item.blue_y});
		wx    = signed'({1'b0, item.white_x});
		wy    = signed'({1'b0, item.white_y});
		dy[0] = ys[1] - ys[2];
		dy[1] = ys[2] - ys[0];
		dy[2] = ys[0] - ys[1];
		dx[0] = xs[2] - xs[1];
		dx[1] = xs[0] - xs[2];
		dx[2] = xs[1] - xs[0];
		for (int k = 0; k < 3; k++) begin
			cz[k] = ONE_V - (CW+2)'(xs[k]) - (CW+2)'(ys[k]);
			cabs_c[3*k]   = CAW'(xs[k]);
			cneg_c[3*k]   = 1'b0;
			cabs_c[3*k+1] = CAW'(ys[k]);
			cneg_c[3*k+1] = 1'b0;
			cneg_c[3*k+2] = cz[k][CW+1];
			cabs_c[3*k+2] = cz[k][CW+1] ? CAW'(-cz[k]) : CAW'(cz[k]);
		end
	end

	// stage 1: partial products of determinant and cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			dt_s1[0] <= xs[0] * dy[0];
			dt_s1[1] <= xs[1] * dy[1];
			dt_s1[2] <= xs[2] * dy[2];
			for (int k = 0; k < 3; k++) begin
				ax_s1[k] <= dy[k] * wx;
				bw_s1[k] <= dx[k] * wy;
			end
			ca_s1[0] <= ys[2] * xs[1];
			cb_s1[0] <= ys[1] * xs[2];
			ca_s1[1] <= ys[0] * xs[2];
			cb_s1[1] <= xs[0] * ys[2];
			ca_s1[2] <= xs[0] * ys[1];
			cb_s1[2] <= ys[0] * xs[1];
			for (int j = 0; j < NCOL; j++) begin
				cabs_s1[j] <= cabs_c[j];
				cneg_s1[j] <= cneg_c[j];
			end
			lum_s1  <= item.white_lum;
			wy_s1   <= item.white_y;
			degy_s1 <= (item.red_y == '0) || (item.green_y == '0) ||
				(item.blue_y == '0) || (item.white_y == '0);
		end
	end

	// stage 2: sums, lum * |c|
	always_ff @(posedge clk) begin
		if (en) begin
			dd_s2 <= SW'(dt_s1[0]) + SW'(dt_s1[1]) + SW'(dt_s1[2]);
			for (int k = 0; k < 3; k++) begin
				nn_s2[k] <= SW'(ax_s1[k]) + SW'(bw_s1[k]) + SW'(ca_s1[k]) - SW'(cb_s1[k]);
			end
			for (int j = 0; j < NCOL; j++) begin
				lumc_s2[j] <= LCW'(lum_s1) * LCW'(cabs_s1[j]);
				cneg_s2[j] <= cneg_s1[j];
			end
			wy_s2   <= wy_s1;
			degy_s2 <= degy_s1;
		end
	end

	always_comb begin
		dd_abs = dd_s2[SW-1] ? SW'(-dd_s2) : SW'(dd_s2);
		for (int k = 0; k < 3; k++) begin
			nn_abs[k] = nn_s2[k][SW-1] ? SW'(-nn_s2[k]) : SW'(nn_s2[k]);
		end
	end

	// stage 3: divisor |D| * white_y, cofactor magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			den_s3  <= DENW'(dd_abs[MW-1:0]) * DENW'(wy_s2);
			dneg_s3 <= dd_s2[SW-1];
			deg_s3  <= degy_s2 || (dd_s2 == '0);
			for (int k = 0; k < 3; k++) begin
				nmag_s3[k] <= nn_abs[k][MW-1:0];
				nneg_s3[k] <= nn_s2[k][SW-1];
			end
			for (int j = 0; j < NCOL; j++) begin
				lumc_s3[j] <= lumc_s2[j];
				cneg_s3[j] <= cneg_s2[j];
			end
		end
	end

	// stage 4: full numerators and signs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int m = 0; m < 3; m++) begin
					num_s4[3*k+m] <= NUMW'(lumc_s3[3*k+m]) * NUMW'(nmag_s3[k]);
					neg_s4[3*k+m] <= cneg_s3[3*k+m] ^ nneg_s3[k] ^ dneg_s3;
				end
			end
			den_s4 <= den_s3;
			deg_s4 <= deg_s3;
		end
	end

	// stage 5: fold half-divisor rounding into the dividend
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NCOL; j++) begin
				cols_s5[j].num <= {1'b0, num_s4[j], 1'b0} + RW'(den_s4);
				cols_s5[j].neg <= neg_s4[j];
			end
			dden_s5 <= {den_s4, 1'b0};
			deg_s5  <= deg_s4;
		end
	end

	assign cols = cols_s5;
	assign dden = dden_s5;
	assign deg  = deg_s5;

endmodule

// ===== design/rxm_div.sv =====
`timescale 1ns / 1ps
module rxm_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [rxm_pkg::RW-1:0]   num,
	input  logic [rxm_pkg::DPW-1:0]  den,
	input  logic                     neg,
	output logic [rxm_pkg::QW-1:0]   quo,
	output logic                     neg_o
);
	import rxm_pkg::*;

	logic [RW-1:0]  rem_s [QW+1];
	logic [DPW-1:0] den_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic           neg_s [QW+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign neg_s[0] = neg;

	// one restoring step per stage, most significant quotient bit first
	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [RW-1:0] sh;
		logic          ge;
		assign sh = RW'(den_s[j-1]) << (QW - j);
		assign ge = rem_s[j-1] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? rem_s[j-1] - sh : rem_s[j-1];
				quo_s[j] <= {quo_s[j-1][QW-2:0], ge};
				den_s[j] <= den_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	assign quo   = quo_s[QW];
	assign neg_o = neg_s[QW];

endmodule

// ===== design/rgb_to_xyz_matrix_from_primaries.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_ready   primary and white chromaticities, white_lum
// output    out_valid / out_ready nine XYZ column values, degenerate
//
// One transaction per cycle sustained unless the output stalls; the pipeline has
// 5 arithmetic stages, 20 divider stages and one output register.
// The divider pipeline retires one quotient bit per stage for all nine columns.
// Stalls freeze the whole pipeline; a one-entry skid buffer still takes one
// input transaction while a result waits. Reset clears valid bits only.
module rgb_to_xyz_matrix_from_primaries (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rxm_pkg::CW-1:0]          red_x,
	input  logic [rxm_pkg::CW-1:0]          red_y,
	input  logic [rxm_pkg::CW-1:0]          green_x,
	input  logic [rxm_pkg::CW-1:0]          green_y,
	input  logic [rxm_pkg::CW-1:0]          blue_x,
	input  logic [rxm_pkg::CW-1:0]          blue_y,
	input  logic [rxm_pkg::LW-1:0]          white_lum,
	input  logic [rxm_pkg::CW-1:0]          white_x,
	input  logic [rxm_pkg::CW-1:0]          white_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [rxm_pkg::OW-1:0]   red_cx,
	output logic signed [rxm_pkg::OW-1:0]   red_cy,
	output logic signed [rxm_pkg::OW-1:0]   red_cz,
	output logic signed [rxm_pkg::OW-1:0]   green_cx,
	output logic signed [rxm_pkg::OW-1:0]   green_cy,
	output logic signed [rxm_pkg::OW-1:0]   green_cz,
	output logic signed [rxm_pkg::OW-1:0]   blue_cx,
	output logic signed [rxm_pkg::OW-1:0]   blue_cy,
	output logic signed [rxm_pkg::OW-1:0]   blue_cz,
	output logic                            degenerate
);
	import rxm_pkg::*;

	logic           adv;
	logic           skid_full_q;
	item_t          skid_q;
	item_t          in_item;
	item_t          src_item;
	logic           src_valid;
	logic           vld_s [1:DEPTH];
	logic           deg_d [1:QW];

	col_t [8:0]     cols;
	logic [DPW-1:0] dden;
	logic           deg_f;
	logic [QW-1:0]  quo   [NCOL];
	logic           neg_q [NCOL];
	logic [OW-1:0]  res_s26 [NCOL];
	logic           deg_s26;

	assign adv      = !vld_s[DEPTH] || out_ready;
	assign in_ready = !skid_full_q;

	always_comb begin
		in_item.red_x     = red_x;
		in_item.red_y     = red_y;
		in_item.green_x   = green_x;
		in_item.green_y   = green_y;
		in_item.blue_x    = blue_x;
		in_item.blue_y    = blue_y;
		in_item.white_lum = white_lum;
		in_item.white_x   = white_x;
		in_item.white_y   = white_y;
	end

	// skid buffer: holds one transaction taken while the pipeline is frozen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (adv) begin
			skid_full_q <= 1'b0;
		end else if (in_valid && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_valid && !skid_full_q) begin
			skid_q <= in_item;
		end
	end

	assign src_item  = skid_full_q ? skid_q : in_item;
	assign src_valid = skid_full_q || in_valid;

	// valid bits alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= src_valid;
			for (int i = 2; i <= DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	rxm_front u_front (
		.clk  (clk),
		.en   (adv),
		.item (src_item),
		.cols (cols),
		.dden (dden),
		.deg  (deg_f)
	);

	for (genvar j = 0; j < NCOL; j++) begin : g_col
		rxm_div u_div (
			.clk   (clk),
			.en    (adv),
			.num   (cols[j].num),
			.den   (dden),
			.neg   (cols[j].neg),
			.quo   (quo[j]),
			.neg_o (neg_q[j])
		);
	end

	// degenerate flag follows the divider stages
	always_ff @(posedge clk) begin
		if (adv) begin
			deg_d[1] <= deg_f;
			for (int i = 2; i <= QW; i++) begin
				deg_d[i] <= deg_d[i-1];
			end
		end
	end

	// output register: sign, saturation, degenerate zeroing
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NCOL; j++) begin
				res_s26[j] <= col_out(quo[j], neg_q[j], deg_d[QW]);
			end
			deg_s26 <= deg_d[QW];
		end
	end

	assign out_valid  = vld_s[DEPTH];
	assign red_cx     = signed'(res_s26[0]);
	assign red_cy     = signed'(res_s26[1]);
	assign red_cz     = signed'(res_s26[2]);
	assign green_cx   = signed'(res_s26[3]);
	assign green_cy   = signed'(res_s26[4]);
	assign green_cz   = signed'(res_s26[5]);
	assign blue_cx    = signed'(res_s26[6]);
	assign blue_cy    = signed'(res_s26[7]);
	assign blue_cz    = signed'(res_s26[8]);
	assign degenerate = deg_s26;

	// a degenerate result carries all-zero columns
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> red_cx == '0 && red_cy == '0 && red_cz == '0 &&
			green_cx == '0 && green_cy == '0 && green_cz == '0 &&
			blue_cx == '0 && blue_cy == '0 && blue_cz == '0)
		else $error("degenerate result with nonzero column");

	// a transaction taken during a stall lands in the skid buffer
	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !adv |=> skid_full_q)
		else $error("stalled transaction not held in skid buffer");

	// the skid buffer empties whenever the pipeline advances
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && adv |=> !skid_full_q && vld_s[1])
		else $error("skid buffer did not drain into the pipeline");

endmodule

// ===== verif/rxm_checker.sv =====
`timescale 1ns / 1ps
module rxm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  rxm_pkg::item_t                item,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [rxm_pkg::OW-1:0] red_cx,
	input  logic signed [rxm_pkg::OW-1:0] red_cy,
	input  logic signed [rxm_pkg::OW-1:0] red_cz,
	input  logic signed [rxm_pkg::OW-1:0] green_cx,
	input  logic signed [rxm_pkg::OW-1:0] green_cy,
	input  logic signed [rxm_pkg::OW-1:0] green_cz,
	input  logic signed [rxm_pkg::OW-1:0] blue_cx,
	input  logic signed [rxm_pkg::OW-1:0] blue_cy,
	input  logic signed [rxm_pkg::OW-1:0] blue_cz,
	input  logic                          degenerate,
	output int                            errors,
	output int                            outstanding
);
	import rxm_pkg::*;

	typedef logic signed [OW-1:0] colv_t;

	typedef struct {
		colv_t col[NCOL];
		logic  deg;
	} matrix_t;

	matrix_t matrices_due[$];

	// One column entry: lum*c*n/den, rounded half away from zero, saturated
	function automatic colv_t column_value(longint lum, longint c, longint n,
			longint den, bit dneg);
		bit          neg;
		bit          sat;
		logic [127:0] num;
		logic [127:0] q;
		logic [127:0] r;
		longint      ac;
		longint      an;
		neg = ((c < 0) != (n < 0)) != dneg;
		ac  = (c < 0) ? -c : c;
		an  = (n < 0) ? -n : n;
		num = 128'(lum) * 128'(ac) * 128'(an);
		q   = num / 128'(den);
		r   = num - q * 128'(den);
		sat = (q >= 128'(1 << 20));
		if (!sat && (2 * r >= 128'(den)))
			q = q + 1;
		if (neg) begin
			if (sat || q >= 128'(524288))
				return colv_t'(-524288);
			return colv_t'(-longint'(q[63:0]));
		end
		if (sat || q > 128'(524287))
			return colv_t'(524287);
		return colv_t'(q[63:0]);
	endfunction

	// Primary matrix from chromaticities and white point
	function automatic matrix_t primaries_to_matrix(item_t it);
		matrix_t m;
		longint  px[3];
		longint  py[3];
		longint  nn[3];
		longint  d;
		longint  xw;
		longint  yw;
		longint  den;
		longint  lum;
		bit      dneg;
		px[0] = it.red_x;   py[0] = it.red_y;
		px[1] = it.green_x; py[1] = it.green_y;
		px[2] = it.blue_x;  py[2] = it.blue_y;
		xw  = it.white_x;
		yw  = it.white_y;
		lum = it.white_lum;
		d = px[0] * (py[1] - py[2]) + px[1] * (py[2] - py[0]) + px[2] * (py[0] - py[1]);
		nn[0] = (py[1] - py[2]) * xw + (px[2] - px[1]) * yw + (py[2] * px[1] - py[1] * px[2]);
		nn[1] = (py[2] - py[0]) * xw + (px[0] - px[2]) * yw + (py[0] * px[2] - px[0] * py[2]);
		nn[2] = (py[0] - py[1]) * xw + (px[1] - px[0]) * yw + (px[0] * py[1] - py[0] * px[1]);
		for (int k = 0; k < NCOL; k++)
			m.col[k] = '0;
		m.deg = 1'b0;
		if (d == 0 || py[0] == 0 || py[1] == 0 || py[2] == 0 || yw == 0) begin
			m.deg = 1'b1;
			return m;
		end
		dneg = d < 0;
		den  = ((d < 0) ? -d : d) * yw;
		for (int k = 0; k < 3; k++) begin
			m.col[3*k]   = column_value(lum, px[k], nn[k], den, dneg);
			m.col[3*k+1] = column_value(lum, py[k], nn[k], den, dneg);
			m.col[3*k+2] = column_value(lum, (longint'(1) << FRAC_BITS) - px[k] - py[k],
				nn[k], den, dneg);
		end
		return m;
	endfunction

	// Queue on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		matrix_t want;
		colv_t   got[NCOL];
		bit      bad;
		if (!arst_n) begin
			errors      <= 0;
			outstanding <= 0;
			matrices_due.delete();
		end else begin
			if (in_valid && in_ready)
				matrices_due.push_back(primaries_to_matrix(item));
			if (out_valid && out_ready) begin
				got = '{red_cx, red_cy, red_cz, green_cx, green_cy, green_cz,
					blue_cx, blue_cy, blue_cz};
				if (matrices_due.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected output transaction at %0t", $realtime);
				end else begin
					want = matrices_due.pop_front();
					bad  = (want.deg !== degenerate);
					for (int k = 0; k < NCOL; k++)
						if (want.col[k] !== got[k])
							bad = 1'b1;
					if (bad) begin
						errors <= errors + 1;
						if (errors < 10) begin
							$display("column mismatch at %0t: deg exp %0b got %0b",
								$realtime, want.deg, degenerate);
							for (int k = 0; k < NCOL; k++)
								$display("  col %0d exp %0d got %0d", k, want.col[k], got[k]);
						end
					end
				end
			end
			outstanding <= matrices_due.size();
		end
	end

endmodule

// ===== verif/tb_rgb_to_xyz_matrix_from_primaries.sv =====
`timescale 1ns / 1ps
module tb_rgb_to_xyz_matrix_from_primaries;
	import rxm_pkg::*;

	localparam int RANDOM_ITEMS = 1630;
	localparam int CYCLE_LIMIT  = 400000;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	item_t  item;
	logic   out_valid;
	logic   out_ready;
	logic signed [OW-1:0] red_cx, red_cy, red_cz;
	logic signed [OW-1:0] green_cx, green_cy, green_cz;
	logic signed [OW-1:0] blue_cx, blue_cy, blue_cz;
	logic   degenerate;
	int     errors;
	int     outstanding;
	int     phase;          // 0: sender light, receiver heavy; 1: swapped; 2: no idling
	bit     hold_request;
	int     cycles;

	rgb_to_xyz_matrix_from_primaries dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.red_x(item.red_x), .red_y(item.red_y), .green_x(item.green_x),
		.green_y(item.green_y), .blue_x(item.blue_x), .blue_y(item.blue_y),
		.white_lum(item.white_lum), .white_x(item.white_x), .white_y(item.white_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_cx(red_cx), .red_cy(red_cy), .red_cz(red_cz),
		.green_cx(green_cx), .green_cy(green_cy), .green_cz(green_cz),
		.blue_cx(blue_cx), .blue_cy(blue_cy), .blue_cz(blue_cz),
		.degenerate(degenerate)
	);

	rxm_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.item(item), .out_valid(out_valid), .out_ready(out_ready),
		.red_cx(red_cx), .red_cy(red_cy), .red_cz(red_cz),
		.green_cx(green_cx), .green_cy(green_cy), .green_cz(green_cz),
		.blue_cx(blue_cx), .blue_cy(blue_cy), .blue_cz(blue_cz),
		.degenerate(degenerate), .errors(errors), .outstanding(outstanding)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rgb_to_xyz_matrix_from_primaries: mismatch");
			$finish;
		end
	end

	// Receiver: random back-pressure per phase, plus one long hold-off
	always @(posedge clk) begin
		int hold_left;
		int stall_pct;
		stall_pct = (phase == 0) ? 72 : (phase == 1) ? 21 : 0;
		if (hold_request && hold_left == 0) begin
			hold_left    = 300;
			hold_request <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one transaction and wait for it to be taken
	task automatic offer(item_t it);
		bit taken;
		int idle_pct;
		idle_pct = (phase == 0) ? 21 : (phase == 1) ? 72 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		item     <= it;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic item_t make_item(int rx, int ry, int gx, int gy, int bx, int by,
			int lum, int wx, int wy);
		item_t it;
		it.red_x = CW'(rx); it.red_y = CW'(ry); it.green_x = CW'(gx); it.green_y = CW'(gy);
		it.blue_x = CW'(bx); it.blue_y = CW'(by); it.white_lum = LW'(lum);
		it.white_x = CW'(wx); it.white_y = CW'(wy);
		return it;
	endfunction

	// Mostly plausible gamuts with random content; some noise and collinear sets
	function automatic item_t random_item();
		item_t it;
		int    pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom_range(65536), $urandom, $urandom_range(65535, 1));
		end else begin
			it = make_item($urandom_range(48000, 35000), $urandom_range(24000, 18000),
				$urandom_range(22000, 10000), $urandom_range(52000, 35000),
				$urandom_range(12000, 8000), $urandom_range(8000, 2000),
				($urandom_range(9) == 0) ? 65536 : $urandom_range(65536),
				$urandom_range(23000, 19000), $urandom_range(23000, 19000));
			if (pick < 24) begin
				it.blue_x = it.red_x;
				it.blue_y = it.red_y;
			end
		end
		return it;
	endfunction

	initial begin
		item_t directed[$];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_ready    = 1'b0;
		item         = '0;
		phase        = 0;
		hold_request = 1'b0;
		cycles       = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: typical gamut, extremes, zero divisors, sum above one
		directed.push_back(make_item(41943, 21627, 19661, 39322, 9830, 3932, 65536, 20493, 21564));
		directed.push_back(make_item(41943, 21627, 19661, 39322, 9830, 3932, 0, 20493, 21564));
		directed.push_back(make_item(41943, 21627, 19661, 39322, 9830, 3932, 1, 20493, 21564));
		directed.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_item(65535, 65535, 65535, 65535, 65535, 65535, 65536,
			65535, 65535));
		directed.push_back(make_item(65535, 1, 0, 65535, 1, 2, 65536, 65535, 1));
		directed.push_back(make_item(1, 65535, 65535, 1, 1, 1, 65536, 0, 1));
		directed.push_back(make_item(65535, 0, 19661, 39322, 9830, 3932, 65536, 20493, 21564));
		directed.push_back(make_item(41943, 21627, 19661, 0, 9830, 3932, 65536, 20493, 21564));
		directed.push_back(make_item(41943, 21627, 19661, 39322, 9830, 0, 65536, 20493, 21564));
		directed.push_back(make_item(41943, 21627, 19661, 39322, 9830, 3932, 65536, 20493, 0));
		directed.push_back(make_item(10000, 10000, 20000, 20000, 30000, 30000, 65536,
			20000, 20000));
		directed.push_back(make_item(60000, 50000, 19661, 39322, 9830, 3932, 65536, 50000, 40000));
		directed.push_back(make_item(9830, 3932, 19661, 39322, 41943, 21627, 65536, 20493, 21564));
		directed.push_back(make_item(43690, 21845, 13107, 39321, 6554, 65535, 65535, 65535, 1));
		directed.push_back(make_item(32768, 32768, 16384, 49152, 49152, 1, 65536, 21845, 21845));
		directed.push_back(make_item(21845, 43690, 43690, 21845, 1, 1, 32768, 65535, 65535));
		foreach (directed[i])
			offer(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				// drain completely before switching the idling pattern
				in_valid <= 1'b0;
				while (outstanding != 0 || in_valid)
					@(posedge clk);
				phase = 1;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				phase        = 2;
				hold_request = 1'b1;
			end
			offer(random_item());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("rgb_to_xyz_matrix_from_primaries: match");
		else
			$display("rgb_to_xyz_matrix_from_primaries: mismatch");
		$finish;
	end

endmodule

// ===== rgb_to_xyz_matrix_from_primaries.f =====
design/rxm_pkg.sv
design/rxm_front.sv
design/rxm_div.sv
design/rgb_to_xyz_matrix_from_primaries.sv
verif/rxm_checker.sv
verif/tb_rgb_to_xyz_matrix_from_primaries.sv
